FILE: rtl/bqe_pkg.sv
package bqe_pkg;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [15:0]        angle;
    logic [31:0]        extent;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
    logic [7:0]         color_alpha;
  } bqe_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               tex_u;
    logic               tex_v;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic               last_vertex;
  } bqe_out_t;

  localparam logic [2:0] REG_RIGHT_X = 3'd0;
  localparam logic [2:0] REG_RIGHT_Y = 3'd1;
  localparam logic [2:0] REG_RIGHT_Z = 3'd2;
  localparam logic [2:0] REG_UP_X    = 3'd3;
  localparam logic [2:0] REG_UP_Y    = 3'd4;
  localparam logic [2:0] REG_UP_Z    = 3'd5;

  // corner tables indexed by vertex number: 1 means +, 0 means -
  localparam logic [5:0] CORNER_R  = 6'b010110;
  localparam logic [5:0] CORNER_U  = 6'b110100;
  localparam logic [5:0] CORNER_TU = 6'b010110;
  localparam logic [5:0] CORNER_TV = 6'b001011;

endpackage

FILE: rtl/bqe_sine.sv
// Registered sine, Q2.14, four stages from angle to result.
module bqe_sine import bqe_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [15:0] sine
);

  logic [14:0] z1;
  logic        neg1, neg2, neg3;
  logic [14:0] z2a, z3;
  logic [14:0] sq;
  logic [13:0] p1;
  logic [14:0] z2b;
  logic [14:0] p2;
  logic [14:0] zz;
  logic [29:0] sq_full;
  logic [27:0] t1;
  logic [29:0] t2;
  logic [29:0] t3;

  assign sq_full = 30'(zz) * 30'(zz);
  assign t1 = 28'(sq) * 28'd1160;
  assign t2 = 30'(z2b) * 30'(p1);
  assign t3 = 30'(z3) * 30'(p2);

  always_comb begin
    zz = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1   <= zz;
      neg1 <= angle[15];
      sq   <= sq_full[28:14];
      z2a  <= z1;
      neg2 <= neg1;
      p1   <= 14'(15'd10512 - 15'(t1[27:14]));
      z2b  <= sq;
      z3   <= z2a;
      neg3 <= neg2;
      p2   <= 15'd25736 - 15'(t2[29:14]);
      sine <= neg3 ? -16'(t3[28:14]) : 16'(t3[28:14]);
    end
  end

endmodule

FILE: rtl/billboard_quad_expander_core.sv
// Billboard quad expander.
// Path: an input transfer passes the pipe stages, the sequencer hold registers and the output
// register before its first vertex reaches the output. Throughput: the output port emits one vertex
// each cycle while out_stall allows it, and the vertex sequencer at the tail sets that rate.
// Reset (rst, synchronous) clears all valid bits and loads the default camera basis.
module billboard_quad_expander_core import bqe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  bqe_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bqe_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NS = 8;

  logic signed [15:0] bas [6];
  logic [NS-1:0] vld;
  logic adv;
  bqe_in_t pl [NS];
  logic signed [15:0] sn, cs;
  logic signed [16:0] s17, c17;
  logic signed [33:0] pr [12];
  logic signed [20:0] rr [6];
  logic signed [53:0] off [6];
  logic signed [37:0] offs [6];
  logic [2:0] vtx;
  logic signed [37:0] psum [3];
  logic signed [31:0] satv [3];
  bqe_out_t ob;
  logic ov;
  logic seq_busy;
  logic seq_ld;
  logic seq_adv;
  logic last_v;
  logic signed [37:0] ho [6];
  bqe_in_t hp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bas[0] <= 16'sd16384; bas[1] <= '0; bas[2] <= '0;
      bas[3] <= '0; bas[4] <= 16'sd16384; bas[5] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RIGHT_X: bas[0] <= cfg_data;
        REG_RIGHT_Y: bas[1] <= cfg_data;
        REG_RIGHT_Z: bas[2] <= cfg_data;
        REG_UP_X:    bas[3] <= cfg_data;
        REG_UP_Y:    bas[4] <= cfg_data;
        REG_UP_Z:    bas[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe stalls while the last stage holds a particle the sequencer cannot take yet;
  // a new particle loads on the edge that sends the sixth vertex of the previous one
  assign seq_adv = seq_busy && (!ov || !out_stall);
  assign seq_ld = vld[NS-1] && (!seq_busy || (seq_adv && last_v));
  assign adv = !vld[NS-1] || seq_ld;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl[0] <= in_data;
      for (int i = 1; i < NS; i++) pl[i] <= pl[i-1];
    end
  end

  // stages 1..4: sine and cosine
  bqe_sine u_sin (.clk, .en(adv), .angle(pl[0].angle), .sine(sn));
  bqe_sine u_cos (.clk, .en(adv), .angle(pl[0].angle + 16'd16384), .sine(cs));

  assign s17 = 17'(sn);
  assign c17 = 17'(cs);

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 5: basis products; pl[4] aligned with sine output
      for (int j = 0; j < 3; j++) begin
        pr[4*j]   <= 34'(bas[j] * c17);
        pr[4*j+1] <= 34'(bas[j+3] * s17);
        pr[4*j+2] <= 34'(bas[j+3] * c17);
        pr[4*j+3] <= 34'(bas[j] * s17);
      end
      // stage 6: rounded rotated basis
      for (int j = 0; j < 3; j++) begin
        rr[j]   <= 21'((35'(pr[4*j]) + 35'(pr[4*j+1]) + 35'sd8192) >>> 14);
        rr[j+3] <= 21'((35'(pr[4*j+2]) - 35'(pr[4*j+3]) + 35'sd8192) >>> 14);
      end
      // stage 7: scale by extent
      for (int k = 0; k < 6; k++)
        off[k] <= 54'(rr[k]) * $signed({1'b0, pl[6].extent});
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      offs[k] = 38'((off[k] + 54'sd16384) >>> 15);
    end
  end

  // sequencer: holds one particle, emits six vertices
  always_ff @(posedge clk) begin
    if (seq_ld) begin
      for (int k = 0; k < 6; k++) ho[k] <= offs[k];
      hp <= pl[NS-1];
    end
  end

  assign last_v = (vtx == 3'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy <= 1'b0;
      vtx <= '0;
    end else if (seq_ld) begin
      seq_busy <= 1'b1;
      vtx <= '0;
    end else if (seq_adv) begin
      vtx <= last_v ? 3'd0 : vtx + 3'd1;
      if (last_v) seq_busy <= 1'b0;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      psum[j] = 38'($signed(hp[175-32*j -: 32]));
      psum[j] = CORNER_R[vtx] ? psum[j] + ho[j] : psum[j] - ho[j];
      psum[j] = CORNER_U[vtx] ? psum[j] + ho[j+3] : psum[j] - ho[j+3];
      if (psum[j] > 38'sd2147483647) satv[j] = 32'sh7fffffff;
      else if (psum[j] < -38'sd2147483648) satv[j] = 32'sh80000000;
      else satv[j] = psum[j][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (!ov || !out_stall) ov <= seq_busy;
  end

  always_ff @(posedge clk) begin
    if (seq_adv) begin
      ob.vert_x <= satv[0];
      ob.vert_y <= satv[1];
      ob.vert_z <= satv[2];
      ob.tex_u <= CORNER_TU[vtx];
      ob.tex_v <= CORNER_TV[vtx];
      ob.out_red <= hp.color_red;
      ob.out_green <= hp.color_green;
      ob.out_blue <= hp.color_blue;
      ob.out_alpha <= hp.color_alpha;
      ob.last_vertex <= last_v;
    end
  end

  assign out_valid = ov;
  assign out_data = ob;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bqe_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  bqe_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  bqe_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  billboard_quad_expander_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  localparam int CYCLE_LIMIT = 400000;

  logic signed [15:0] basis [6];   // right xyz, up xyz
  bqe_in_t  particle_q [$];
  bqe_out_t vertex_q [$];
  int       errors = 0;
  int       cycles = 0;
  bit       cfg_busy = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Q2.14 sine of a 16-bit fraction of a turn (polynomial)
  function automatic longint sine14(logic [15:0] a);
    logic [1:0] q;
    longint z, z2, p;
    q = a[15:14];
    z = a[13:0];
    if (q[0]) z = 16384 - z;
    z2 = (z * z) >>> 14;
    p = 10512 - ((z2 * 1160) >>> 14);
    p = 25736 - ((z2 * p) >>> 14);
    p = (z * p) >>> 14;
    return q[1] ? -p : p;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic queue_particle(bqe_in_t p);
    particle_q.insert(particle_q.size(), p);
  endtask

  task automatic expand_particle(bqe_in_t p);
    longint s, c, ext, rb, ub, r, u;
    longint ctr [3];
    longint roff [3];
    longint uoff [3];
    longint pos;
    bqe_out_t v;
    s = sine14(p.angle);
    c = sine14(p.angle + 16'd16384);
    ext = longint'({32'd0, p.extent});
    for (int j = 0; j < 3; j++) begin
      rb = basis[j];
      ub = basis[j + 3];
      // >>> on longint is an arithmetic shift, i.e. floor division
      r = (rb * c + ub * s + 8192) >>> 14;
      u = (ub * c - rb * s + 8192) >>> 14;
      roff[j] = (r * ext + 16384) >>> 15;
      uoff[j] = (u * ext + 16384) >>> 15;
    end
    ctr[0] = p.center_x;
    ctr[1] = p.center_y;
    ctr[2] = p.center_z;
    for (int k = 0; k < 6; k++) begin
      v = '0;
      for (int j = 0; j < 3; j++) begin
        pos = ctr[j] + (CORNER_R[k] ? roff[j] : -roff[j])
                     + (CORNER_U[k] ? uoff[j] : -uoff[j]);
        case (j)
          0: v.vert_x = clamp32(pos);
          1: v.vert_y = clamp32(pos);
          default: v.vert_z = clamp32(pos);
        endcase
      end
      v.tex_u = CORNER_TU[k];
      v.tex_v = CORNER_TV[k];
      v.out_red = p.color_red;
      v.out_green = p.color_green;
      v.out_blue = p.color_blue;
      v.out_alpha = p.color_alpha;
      v.last_vertex = (k == 5);
      vertex_q.insert(vertex_q.size(), v);
    end
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expand_particle(in_data);
        in_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || particle_q.size() == 0 || cfg_busy) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_data <= particle_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    bqe_out_t e;
    cycles++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (vertex_q.size() == 0) begin
          $error("vertex transfer with none expected");
          errors++;
        end else begin
          e = vertex_q.pop_front();
          if (out_data.vert_x !== e.vert_x) begin
            $error("vert_x exp %0d got %0d", e.vert_x, out_data.vert_x); errors++;
          end
          if (out_data.vert_y !== e.vert_y) begin
            $error("vert_y exp %0d got %0d", e.vert_y, out_data.vert_y); errors++;
          end
          if (out_data.vert_z !== e.vert_z) begin
            $error("vert_z exp %0d got %0d", e.vert_z, out_data.vert_z); errors++;
          end
          if (out_data.tex_u !== e.tex_u) begin
            $error("tex_u exp %0d got %0d", e.tex_u, out_data.tex_u); errors++;
          end
          if (out_data.tex_v !== e.tex_v) begin
            $error("tex_v exp %0d got %0d", e.tex_v, out_data.tex_v); errors++;
          end
          if (out_data.out_red !== e.out_red) begin
            $error("out_red exp %0d got %0d", e.out_red, out_data.out_red); errors++;
          end
          if (out_data.out_green !== e.out_green) begin
            $error("out_green exp %0d got %0d", e.out_green, out_data.out_green); errors++;
          end
          if (out_data.out_blue !== e.out_blue) begin
            $error("out_blue exp %0d got %0d", e.out_blue, out_data.out_blue); errors++;
          end
          if (out_data.out_alpha !== e.out_alpha) begin
            $error("out_alpha exp %0d got %0d", e.out_alpha, out_data.out_alpha); errors++;
          end
          if (out_data.last_vertex !== e.last_vertex) begin
            $error("last_vertex exp %0d got %0d", e.last_vertex, out_data.last_vertex);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = gap_len();
        out_stall <= (out_gap > 0);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // leaves cfg_valid high; the caller drops it after the last write of a sequence
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_UP_Z) basis[idx] = val;
  endtask

  task automatic drain();
    while (particle_q.size() != 0 || in_valid || vertex_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic bqe_in_t rand_particle(bit small_ext);
    bqe_in_t p;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(bqe_in_t)-1:0];
    if ($urandom_range(0, 3) != 0) begin
      p.center_x = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      p.center_y = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      p.center_z = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    end
    if (small_ext) p.extent = $urandom_range(0, 32'h00ffffff);
    return p;
  endfunction

  task automatic set_basis(logic [15:0] rx, ry, rz, ux, uy, uz);
    write_reg(REG_RIGHT_X, rx);
    write_reg(REG_RIGHT_Y, ry);
    write_reg(REG_RIGHT_Z, rz);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
  endtask

  initial begin
    bqe_in_t p;
    basis[0] = 16384; basis[1] = 0; basis[2] = 0;
    basis[3] = 0; basis[4] = 16384; basis[5] = 0;
    cfg_busy = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_busy = 0;

    // directed: angles at every eighth of a turn, extremes of fields
    for (int i = 0; i < 8; i++) begin
      p = '0;
      p.angle = 16'(i * 8192);
      p.extent = 32'h00020000;
      p.color_red = 8'hff; p.color_blue = 8'h5a;
      queue_particle(p);
    end
    p = '1; p.center_x = 32'sh7fffffff; p.center_y = 32'sh80000000; p.angle = 16'hffff;
    queue_particle(p);
    p = '0; p.center_x = 32'sh80000000; p.center_y = 32'sh7fffffff;
    p.center_z = 32'sh7fff0000; p.extent = 32'hffffffff; p.angle = 16'h2000;
    queue_particle(p);
    p = '0; p.extent = 32'h00000001; p.color_green = 8'hff; p.color_alpha = 8'hff;
    queue_particle(p);
    p = '0; p.extent = 32'h00000003; p.angle = 16'h4000; p.center_z = -32'sd1;
    queue_particle(p);
    drain();

    // extreme basis, out of range values, two ignored indices
    cfg_busy = 1;
    set_basis(16'h8000, 16'h7fff, 16'hc000, 16'h7fff, 16'h8000, 16'h4000);
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hffff);
    cfg_valid <= 1'b0;
    cfg_busy = 0;
    for (int i = 0; i < 6; i++) queue_particle(rand_particle(i < 3));
    p = '1; p.extent = 32'hffffffff; queue_particle(p);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_busy = 1;
      case (ph)
        0: set_basis(16'd16384, 0, 0, 0, 16'd16384, 0);
        1: set_basis(-16'sd16384, 0, 0, 0, -16'sd16384, 0);
        2: set_basis(0, 0, 16'd16384, 16'd16384, 0, 0);
        3: set_basis(16'd11585, 16'd11585, 0, -16'sd11585, 16'd11585, 0);
        default: set_basis($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
      endcase
      cfg_valid <= 1'b0;
      cfg_busy = 0;
      for (int i = 0; i < 58; i++) queue_particle(rand_particle($urandom_range(0, 4) != 0));
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/bqe_pkg.sv
rtl/bqe_sine.sv
rtl/billboard_quad_expander_core.sv
test/testbench.sv
